@@ rtl/core/crc16a_pkg.sv @@
package crc16a_pkg;

  localparam int unsigned CrcWidth = 16;

  localparam logic [CrcWidth-1:0] StartValue = 16'hFFFF;
  localparam logic [CrcWidth-1:0] PolyReset  = 16'h1021;

  // one pipeline register's contents passed to the next stage
  typedef struct packed {
    logic                valid;
    logic [CrcWidth-1:0] value;
  } crc16a_xfer_t;

  // eight MSB-first bit steps of the augmented shift register
  function automatic logic [CrcWidth-1:0] shift8(
    input logic [CrcWidth-1:0] rem_in,
    input logic [7:0]          bits,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] r;
    logic                msb;
    r = rem_in;
    for (int k = 0; k < 8; k++) begin
      msb = r[CrcWidth-1];
      r = {r[CrcWidth-2:0], bits[7-k]} ^ (msb ? poly : '0);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/crc16a_byte_stage.sv @@
module crc16a_byte_stage
  import crc16a_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [CrcWidth-1:0] poly,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                end_of_message,
  input  logic                dn_stall,
  output crc16a_xfer_t        dn
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_present;
  logic                s1_end;
  logic [CrcWidth-1:0] remainder;
  logic [CrcWidth-1:0] remainder_next;
  logic [CrcWidth-1:0] rem_byte;
  logic                a1_valid;
  logic [CrcWidth-1:0] a1_value;
  logic                a1_take;
  logic                s1_go;
  logic                s1_take;

  assign rem_byte = s1_present ? shift8(remainder, s1_byte, poly) : remainder;

  assign a1_take  = !a1_valid || !dn_stall;
  // non-end items retire here; end items need room in the augment pipe
  assign s1_go    = s1_valid && (!s1_end || a1_take);
  assign s1_take  = !s1_valid || s1_go;
  assign in_stall = !s1_take;

  assign remainder_next = s1_end ? StartValue : rem_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      a1_valid  <= 1'b0;
      remainder <= StartValue;
    end else begin
      if (s1_take) begin
        s1_valid <= in_valid;
      end
      if (a1_take) begin
        a1_valid <= s1_go && s1_end;
      end
      if (s1_go) begin
        remainder <= remainder_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_byte    <= data_byte;
      s1_present <= byte_present;
      s1_end     <= end_of_message;
    end
    if (a1_take) begin
      a1_value <= rem_byte;
    end
  end

  assign dn.valid = a1_valid;
  assign dn.value = a1_value;

endmodule

@@ rtl/core/crc16a_zero_stage.sv @@
module crc16a_zero_stage
  import crc16a_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [CrcWidth-1:0] poly,
  input  crc16a_xfer_t        up,
  output logic                up_stall,
  input  logic                dn_stall,
  output crc16a_xfer_t        dn
);

  logic                vld;
  logic [CrcWidth-1:0] value;
  logic                take;

  assign take     = !vld || !dn_stall;
  assign up_stall = !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= up.valid;
    end
  end

  // one augmentation zero byte
  always_ff @(posedge clk) begin
    if (take) begin
      value <= shift8(up.value, 8'h00, poly);
    end
  end

  assign dn.valid = vld;
  assign dn.value = value;

endmodule

@@ rtl/core/crc16_augmented_msb_first.sv @@
// Augmented CRC-16, MSB first, with a programmable generator polynomial
// (x^16 implied, 0x1021 after reset). The remainder starts at 0xFFFF. Each
// input transfer with byte_present set shifts data_byte in MSB first; a
// transfer with end_of_message set then shifts in two zero bytes, delivers the
// 16-bit remainder on crc_value, and reloads 0xFFFF for the next message. An
// end transfer without a byte gives the CRC of the bytes sent so far (the
// empty message right after reset). Transfers with neither flag do nothing.
// One transfer is taken per cycle unless in_stall is high; an end transfer
// passes the input register, byte step, then one zero byte per stage, the last
// stage being the output register. Only end transfers produce output; others
// retire after the byte step. Write the polynomial only while the pipe is
// empty; cfg_ready is always high and the new value applies to the next bit.
module crc16_augmented_msb_first
  import crc16a_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CrcWidth-1:0] cfg_data,
  // message input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                end_of_message,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CrcWidth-1:0] crc_value
);

  logic [CrcWidth-1:0] poly;
  crc16a_xfer_t        byte_to_z1;
  crc16a_xfer_t        z1_to_z2;
  crc16a_xfer_t        z2_out;
  logic                z1_stall;
  logic                z2_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= PolyReset;
    end else if (cfg_valid && cfg_ready) begin
      poly <= cfg_data;
    end
  end

  // input register, running remainder, byte step
  crc16a_byte_stage u_byte (
    .clk            (clk),
    .rst            (rst),
    .poly           (poly),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .dn_stall       (z1_stall),
    .dn             (byte_to_z1)
  );

  // first augmentation byte
  crc16a_zero_stage u_zero1 (
    .clk      (clk),
    .rst      (rst),
    .poly     (poly),
    .up       (byte_to_z1),
    .up_stall (z1_stall),
    .dn_stall (z2_stall),
    .dn       (z1_to_z2)
  );

  // second augmentation byte, doubles as the output register
  crc16a_zero_stage u_zero2 (
    .clk      (clk),
    .rst      (rst),
    .poly     (poly),
    .up       (z1_to_z2),
    .up_stall (z2_stall),
    .dn_stall (out_stall),
    .dn       (z2_out)
  );

  assign out_valid = z2_out.valid;
  assign crc_value = z2_out.value;

endmodule

@@ rtl/core/crc16a_checker.sv @@
module crc16a_checker
  import crc16a_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [CrcWidth-1:0] cfg_data,
  input logic                in_valid,
  input logic                in_stall,
  input logic [7:0]          data_byte,
  input logic                byte_present,
  input logic                end_of_message,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CrcWidth-1:0] crc_value
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(crc_value))
    else $error("stalled result changed");

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when the output register is full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind crc16_augmented_msb_first crc16a_checker u_crc16a_checker (.*);

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16a_pkg::*;

  // one message transfer as the sender sees it
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CrcWidth-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = '0;
  logic                byte_present = 1'b0;
  logic                end_of_message = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CrcWidth-1:0] crc_value;

  crc16_augmented_msb_first dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .crc_value      (crc_value)
  );

  // Pending message transfers, filled by the sequence below, drained by the driver.
  msg_item_t           pending[$];
  // CRC values still owed by the block, oldest first.
  logic [CrcWidth-1:0] crc_expect[$];

  // Shadow of the block: running remainder and the programmed polynomial.
  logic [CrcWidth-1:0] crc_state = StartValue;
  logic [CrcWidth-1:0] poly_shadow = PolyReset;

  int unsigned in_count = 0;    // accepted input transfers (updated with NBA)
  int unsigned mismatches = 0;

  // Long receiver hold-off: loaded once, counted down in the receiver process.
  localparam int unsigned HoldAt     = 250;
  localparam int unsigned HoldCycles = 120;
  // Window of accepted inputs with no random idling on either side.
  localparam int unsigned BusyFrom   = 450;
  localparam int unsigned BusyTo     = 620;
  localparam int unsigned IdlePct    = 7;
  // Margin after the drain condition so the pipe has emptied.
  localparam int unsigned DrainCycles = 8;

  initial begin
    forever #1 clk = ~clk;
  end

  // Shift count bits (MSB first, taken from bits[count-1:0]) into the
  // remainder. A one falling out of the top folds the polynomial back in.
  function automatic logic [CrcWidth-1:0] crc_shift(
    input logic [CrcWidth-1:0] rem_in,
    input logic [23:0]         bits,
    input int                  count,
    input logic [CrcWidth-1:0] gen
  );
    logic [CrcWidth-1:0] r;
    logic                top;
    r = rem_in;
    for (int k = count - 1; k >= 0; k--) begin
      top = r[CrcWidth-1];
      r = {r[CrcWidth-2:0], bits[k]};
      if (top) r = r ^ gen;
    end
    return r;
  endfunction

  // Advance the shadow remainder by one accepted transfer; an end transfer
  // appends two zero bytes, owes one CRC value and restarts the remainder.
  task automatic fold_transfer(input msg_item_t it);
    logic [CrcWidth-1:0] r;
    r = crc_state;
    if (it.byte_present) r = crc_shift(r, {16'h0, it.data_byte}, 8, poly_shadow);
    if (it.end_of_message) begin
      r = crc_shift(r, 24'h0, 16, poly_shadow);
      crc_expect.push_back(r);
      r = StartValue;
    end
    crc_state = r;
  endtask

  function automatic logic idle_allowed();
    return !(in_count >= BusyFrom && in_count < BusyTo);
  endfunction

  // Driver: holds a stalled transfer steady, otherwise offers the next
  // pending item unless it randomly idles this cycle.
  msg_item_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_transfer(on_bus);
        in_count <= in_count + 1;
      end
      if (in_valid && in_stall) begin
        // stalled: payload and valid stay as they are
      end else if (pending.size() != 0 &&
                   !(idle_allowed() && $urandom_range(99) < IdlePct)) begin
        on_bus = pending.pop_front();
        in_valid       <= 1'b1;
        data_byte      <= on_bus.data_byte;
        byte_present   <= on_bus.byte_present;
        end_of_message <= on_bus.end_of_message;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transfer against the oldest owed CRC and
  // drives out_stall, including one long hold-off so the pipe backs up.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk) begin
    logic [CrcWidth-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crc_expect.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer: crc_value=%h", crc_value);
          mismatches++;
        end else begin
          want = crc_expect.pop_front();
          if (crc_value !== want) begin
            if (mismatches < 10)
              $display("crc_value mismatch: expected %h, got %h", want, crc_value);
            mismatches++;
          end
        end
      end
      if (!hold_done && in_count >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0) || (idle_allowed() && $urandom_range(99) < IdlePct);
    end
  end

  task automatic add_item(input logic [7:0] d, input logic p, input logic l);
    msg_item_t it;
    it.data_byte      = d;
    it.byte_present   = p;
    it.end_of_message = l;
    pending.push_back(it);
  endtask

  // Sender pause: nothing queued, nothing on the bus, nothing owed, then a
  // few extra cycles so a byte-only transfer has retired from the pipe too.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || crc_expect.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Polynomial write; only called with the block drained.
  task automatic write_poly(input logic [CrcWidth-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    poly_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed messages with random bytes; some empty items as noise,
  // the odd long message, and end transfers with and without a byte.
  task automatic gen_messages(input int unsigned n);
    int unsigned made;
    int unsigned len;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 8) begin
        add_item(8'($urandom), 1'b0, 1'b0);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        for (int unsigned k = 0; k < len; k++) begin
          add_item(8'($urandom), 1'b1, 1'b0);
          made++;
          if ($urandom_range(99) < 4) add_item(8'($urandom), 1'b0, 1'b0);
        end
        add_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
        made++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset polynomial.
    add_item(8'h00, 1'b0, 1'b1);             // empty message straight from reset
    add_item(8'hA5, 1'b0, 1'b0);             // empty item, ignored
    add_item(8'h00, 1'b1, 1'b1);             // single zero byte
    for (int i = 1; i <= 9; i++)             // "123456789" check string
      add_item(8'(8'h30 + i), 1'b1, (i == 9));
    add_item(8'hFF, 1'b1, 1'b1);             // all-ones byte
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h3C, 1'b0, 1'b0);             // empty item inside a message
    add_item(8'h01, 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b1);             // end-only after bytes
    add_item(8'h00, 1'b0, 1'b1);             // empty message again
    add_item(8'hC3, 1'b1, 1'b0);             // left open across the next write
    wait_drained();

    // Polynomial changes mid-message: zero polynomial, then all ones.
    write_poly(16'h0000);
    add_item(8'h7E, 1'b1, 1'b0);
    add_item(8'h81, 1'b1, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h55, 1'b1, 1'b0);
    wait_drained();
    write_poly(16'hFFFF);
    add_item(8'hAA, 1'b1, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    // Random part across several polynomials; the hold-off and the no-idle
    // stretch fall inside it. Some phases end with a message left open.
    write_poly(16'h8005);
    gen_messages(140);
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      write_poly(16'($urandom_range(65535)));
      gen_messages(140);
      if (p[0]) add_item(8'($urandom), 1'b1, 1'b0);
      wait_drained();
    end
    write_poly(PolyReset);
    add_item(8'($urandom), 1'b1, 1'b1);
    wait_drained();

    if (mismatches == 0 && crc_expect.size() == 0) begin
      $display("PASS crc16_augmented_msb_first");
    end else begin
      $display("FAIL crc16_augmented_msb_first");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("FAIL crc16_augmented_msb_first");
    $finish;
  end

endmodule

@@ crc16_augmented_msb_first.f @@
rtl/core/crc16a_pkg.sv
rtl/core/crc16a_byte_stage.sv
rtl/core/crc16a_zero_stage.sv
rtl/core/crc16_augmented_msb_first.sv
rtl/core/crc16a_checker.sv
tb/tb.sv
